// File: rtl/mlfq_pkg.sv
package mlfq_pkg;

  // Fixed shape of the scheduler.
  localparam int LEVELS            = 3;
  localparam int DEF_PROCESS_SLOTS = 16;
  localparam int SLOT_W            = 4;
  localparam int TIME_W            = 16;
  localparam int SLICE_W           = 8;
  localparam int LVL_W             = 2;
  localparam int CFG_IDX_W         = 2;

  localparam logic [LVL_W-1:0] LVL_FIRST  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LOWEST = 2'd2;

  // Commands carried by an input item.
  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLICE0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE2 = 2'd2;

  localparam logic [SLICE_W-1:0] SLICE0_RST = 8'd2;
  localparam logic [SLICE_W-1:0] SLICE1_RST = 8'd4;
  localparam logic [SLICE_W-1:0] SLICE2_RST = 8'd8;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_TERMINATED = 3'd1,
    ST_DEMOTED    = 3'd2,
    ST_REQUEUED   = 3'd3,
    ST_ADMITTED   = 3'd4,
    ST_REJECTED   = 3'd5
  } status_t;

  typedef enum logic {
    FSM_WAIT = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_t;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] burst;
  } sched_in_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot_res;
    logic [LVL_W-1:0]   level;
    logic [SLICE_W-1:0] ran;
    logic [TIME_W-1:0]  left;
  } sched_out_t;

  // One queue entry: the slot and its remaining run time travel together.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] left;
  } q_entry_t;

  // Update request from the sequencer to the level bookkeeping.
  typedef struct packed {
    logic              pop;
    logic [LVL_W-1:0]  lvl_pop;
    logic              push;
    logic [LVL_W-1:0]  lvl_push;
    logic              mark_set;
    logic              mark_clr;
    logic [SLOT_W-1:0] slot;
  } lvl_upd_t;

  // Highest-priority non-empty level.
  typedef struct packed {
    logic             any;
    logic [LVL_W-1:0] lvl;
  } lvl_pick_t;

endpackage

// File: rtl/mlfq_scheduler_tick.sv
// Three-level feedback queue scheduler.
// Input channel (in_valid, in_ready, in_item) carries one command per item:
// an admit places a slot with its burst time at the tail of level 0, a tick
// runs the head of the highest-priority non-empty level for the smaller of
// that level's slice and its remaining time, then retires, demotes or
// requeues it; an admit of a busy or out-of-range slot or of a zero burst is
// rejected. Every item yields exactly one result item on the output channel
// (out_valid, out_ready, out_item). In the accept step the head entry of the
// chosen level is read from the queue memory; in the execute step, once the
// output register is free, the entry is updated, written back at the tail of
// its new level unless it retires, and the result is loaded into the output
// register. No new item is accepted until the execute step of the last one is
// done. The output register lets a new item be accepted while a result waits; if
// the receiver still holds off when the next result is ready, the block
// waits in its execute step and takes no further item.
// Reset empties all levels and clears the busy marks at once (no clearing
// pass is needed) and loads the slices with 2, 4 and 8 ticks. The slices are
// written through cfg_we, cfg_index and cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce it.
module mlfq_scheduler_tick import mlfq_pkg::*; #(
  parameter int PROCESS_SLOTS = DEF_PROCESS_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sched_in_t            in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sched_out_t           out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLICE_W-1:0]   cfg_data
);

  localparam int DEPTH = 3 * PROCESS_SLOTS;
  localparam int AW    = $clog2(DEPTH);

  fsm_state_t state, state_next;

  // Item held for the execute step.
  sched_in_t item_q;

  // Slice registers, one per level.
  logic [SLICE_W-1:0] slice_reg [LEVELS];

  lvl_pick_t     pick;
  lvl_upd_t      upd_raw, upd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en;
  logic          slot_free;
  q_entry_t      rd_data, wr_data;
  sched_out_t    res;
  logic          fire;

  logic [SLICE_W-1:0] slice_sel;
  logic [SLICE_W-1:0] run;
  logic [TIME_W-1:0]  left_v;

  mlfq_level_ctrl #(
    .PROCESS_SLOTS (PROCESS_SLOTS),
    .AW            (AW)
  ) u_levels (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd),
    .pick      (pick),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .chk_slot  (item_q.slot),
    .slot_free (slot_free)
  );

  mlfq_queue_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (upd.push),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Configuration writes; an index beyond the slice registers is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_reg[0] <= SLICE0_RST;
      slice_reg[1] <= SLICE1_RST;
      slice_reg[2] <= SLICE2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLICE0: slice_reg[0] <= cfg_data;
        REG_SLICE1: slice_reg[1] <= cfg_data;
        REG_SLICE2: slice_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The counts do not move between accept and execute, so the pick made
  // for the memory read is still the right one in the execute step.
  always_comb begin
    slice_sel = slice_reg[pick.lvl];
    run       = ({8'b0, slice_sel} < rd_data.left) ? slice_sel
                                                   : rd_data.left[SLICE_W-1:0];
    left_v    = rd_data.left - TIME_W'(run);
  end

  // Result, bookkeeping update and write-back entry for the held item.
  always_comb begin
    res            = '0;
    res.status     = ST_IDLE;
    upd_raw        = '0;
    wr_data        = '0;
    if (item_q.command == CMD_ADMIT) begin
      res.slot_res = item_q.slot;
      res.level    = LVL_FIRST;
      res.left     = item_q.burst;
      if (slot_free && item_q.burst != '0) begin
        res.status       = ST_ADMITTED;
        upd_raw.push     = 1'b1;
        upd_raw.lvl_push = LVL_FIRST;
        upd_raw.mark_set = 1'b1;
        upd_raw.slot     = item_q.slot;
        wr_data.slot     = item_q.slot;
        wr_data.left     = item_q.burst;
      end else begin
        res.status       = ST_REJECTED;
      end
    end else if (pick.any) begin
      res.slot_res    = rd_data.slot;
      res.level       = pick.lvl;
      res.ran         = run;
      res.left        = left_v;
      upd_raw.pop     = 1'b1;
      upd_raw.lvl_pop = pick.lvl;
      upd_raw.slot    = rd_data.slot;
      wr_data.slot    = rd_data.slot;
      wr_data.left    = left_v;
      if (left_v == '0) begin
        res.status       = ST_TERMINATED;
        upd_raw.mark_clr = 1'b1;
      end else if (pick.lvl == LVL_LOWEST) begin
        res.status       = ST_REQUEUED;
        upd_raw.push     = 1'b1;
        upd_raw.lvl_push = LVL_LOWEST;
      end else begin
        res.status       = ST_DEMOTED;
        upd_raw.push     = 1'b1;
        upd_raw.lvl_push = pick.lvl + LVL_W'(1);
      end
    end
  end

  // Sequencer: accept and read, then execute once the output register is free.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    fire       = 1'b0;
    unique case (state)
      FSM_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_en      = (in_item.command == CMD_TICK);
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!out_valid || out_ready) begin
          fire       = 1'b1;
          state_next = FSM_WAIT;
        end
      end
      default: state_next = FSM_WAIT;
    endcase
  end

  // Updates reach the levels and the memory only in the cycle that retires.
  always_comb begin
    upd = upd_raw;
    if (!fire) begin
      upd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= res;
    end
  end

endmodule

// File: rtl/mlfq_queue_mem.sv
module mlfq_queue_mem import mlfq_pkg::*; #(
  parameter int DEPTH = 3 * DEF_PROCESS_SLOTS,
  parameter int AW    = $clog2(3 * DEF_PROCESS_SLOTS)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output q_entry_t      rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  q_entry_t      wr_data
);

  q_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is held until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/mlfq_levels.sv
module mlfq_level_ctrl import mlfq_pkg::*; #(
  parameter int PROCESS_SLOTS = DEF_PROCESS_SLOTS,
  parameter int AW            = $clog2(3 * DEF_PROCESS_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  lvl_upd_t          upd,
  output lvl_pick_t         pick,
  output logic [AW-1:0]     rd_addr,
  output logic [AW-1:0]     wr_addr,
  input  logic [SLOT_W-1:0] chk_slot,
  output logic              slot_free
);

  localparam int HW = $clog2(PROCESS_SLOTS);
  localparam int CW = $clog2(PROCESS_SLOTS + 1);
  localparam int TW = CW + 1;
  localparam int SW = $clog2(PROCESS_SLOTS);
  localparam logic [AW-1:0] BASE1 = AW'(PROCESS_SLOTS);
  localparam logic [AW-1:0] BASE2 = AW'(2 * PROCESS_SLOTS);
  localparam logic [HW-1:0] HEAD_LAST = HW'(PROCESS_SLOTS - 1);
  localparam logic [TW-1:0] WRAP = TW'(PROCESS_SLOTS);

  logic [HW-1:0] head   [LEVELS];
  logic [CW-1:0] count  [LEVELS];
  logic          queued [PROCESS_SLOTS];

  logic [TW-1:0] tail_sum;
  logic [HW-1:0] tail_pos;
  logic          in_range;

  function automatic logic [AW-1:0] level_base(input logic [LVL_W-1:0] l);
    logic [AW-1:0] b;
    unique case (l)
      2'd0:    b = '0;
      2'd1:    b = BASE1;
      default: b = BASE2;
    endcase
    return b;
  endfunction

  // Priority pick over the three levels.
  always_comb begin
    pick.any = 1'b1;
    pick.lvl = LVL_LOWEST;
    if (count[0] != '0) begin
      pick.lvl = LVL_FIRST;
    end else if (count[1] != '0) begin
      pick.lvl = 2'd1;
    end else if (count[2] == '0) begin
      pick.any = 1'b0;
    end
  end

  assign rd_addr = level_base(pick.lvl) + AW'(head[pick.lvl]);

  // Tail position; head + count stays below twice the depth.
  always_comb begin
    tail_sum = TW'(head[upd.lvl_push]) + TW'(count[upd.lvl_push]);
    if (tail_sum >= WRAP) begin
      tail_sum = tail_sum - WRAP;
    end
    tail_pos = tail_sum[HW-1:0];
  end

  assign wr_addr = level_base(upd.lvl_push) + AW'(tail_pos);

  assign in_range  = 32'(chk_slot) < PROCESS_SLOTS;
  assign slot_free = in_range && !queued[SW'(chk_slot)];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        head[l]  <= '0;
        count[l] <= '0;
      end
      for (int s = 0; s < PROCESS_SLOTS; s++) begin
        queued[s] <= 1'b0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        if (upd.pop && upd.lvl_pop == LVL_W'(l)) begin
          head[l] <= (head[l] == HEAD_LAST) ? '0 : head[l] + HW'(1);
        end
        if (upd.pop && upd.lvl_pop == LVL_W'(l) &&
            !(upd.push && upd.lvl_push == LVL_W'(l))) begin
          count[l] <= count[l] - CW'(1);
        end else if (upd.push && upd.lvl_push == LVL_W'(l) &&
                     !(upd.pop && upd.lvl_pop == LVL_W'(l))) begin
          count[l] <= count[l] + CW'(1);
        end
      end
      if (upd.mark_set) begin
        queued[SW'(upd.slot)] <= 1'b1;
      end else if (upd.mark_clr) begin
        queued[SW'(upd.slot)] <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/mlfq_checker.sv
module mlfq_checker import mlfq_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input sched_out_t           out_item
);

  // No result is left over after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Items are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  // With the output free when the item is taken, the result follows its execute step without a stall.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (!out_valid || out_ready)) |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  // A retired process has run at least one tick and has nothing left.
  a_retire: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == ST_TERMINATED) |->
      (out_item.left == '0 && out_item.ran != '0))
    else $error("terminated result inconsistent");

endmodule

bind mlfq_scheduler_tick mlfq_checker u_mlfq_checker (.*);

// File: tb/tb_mlfq_scheduler_tick.sv
module tb_mlfq_scheduler_tick;
  import mlfq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 of the register port selects no register; a write there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Random traffic: six phases of this many items each, after the directed table.
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 305;
  // Length of the long receiver hold-off in the pressure phase, in cycles.
  localparam int HOLD_CYCLES = 300;
  // Bound on waiting for outstanding results before a phase change or the end.
  localparam int DRAIN_LIMIT = 20000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sched_in_t            in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sched_out_t           out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SLICE_W-1:0]   cfg_data = '0;

  mlfq_scheduler_tick dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // The run is ended here if the traffic ever locks up.
  initial begin
    #5_000_000;
    $display("FAIL mlfq_scheduler_tick");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Scheduler mirror. It keeps its own copy of the three ready lists (each a
  // circular buffer with a head pointer and a fill count), the remaining run
  // time of every slot, the busy mark of every slot and the three slices.
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0]  ready_ring [LEVELS][DEF_PROCESS_SLOTS];
  int                 ring_head  [LEVELS];
  int                 ring_fill  [LEVELS];
  logic [TIME_W-1:0]  time_owed  [DEF_PROCESS_SLOTS];
  bit                 slot_busy  [DEF_PROCESS_SLOTS];
  logic [SLICE_W-1:0] slice_now  [LEVELS];

  // Expected result items, oldest first.
  sched_out_t pending_results [$];

  int mismatches;
  int n_admitted, n_turned_away, n_idle, n_finished, n_moved_down, n_kept_low;
  int n_reg_writes;

  // Traffic shaping, written by the stimulus process only.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_asked;

  function automatic void enqueue(int lv, logic [SLOT_W-1:0] who);
    int pos;
    // With sixteen slots a level can never overflow, but the guard mirrors the
    // bookkeeping of a bounded list.
    if (ring_fill[lv] >= DEF_PROCESS_SLOTS) return;
    pos = (ring_head[lv] + ring_fill[lv]) % DEF_PROCESS_SLOTS;
    ready_ring[lv][pos] = who;
    ring_fill[lv]++;
  endfunction

  // Works out the result of one command and advances the mirrored state.
  function automatic sched_out_t schedule_step(sched_in_t it);
    sched_out_t        r;
    int                lv;
    logic [SLOT_W-1:0] who;
    logic [TIME_W-1:0] owed, run, rest;
    r = '0;
    if (it.command == CMD_ADMIT) begin
      r.slot_res = it.slot;
      r.level    = LVL_FIRST;
      r.left     = it.burst;
      // A slot already waiting in some level, or a zero burst, is turned away
      // without touching any state.
      if (slot_busy[it.slot] || it.burst == '0) begin
        r.status = ST_REJECTED;
        n_turned_away++;
      end else begin
        time_owed[it.slot] = it.burst;
        slot_busy[it.slot] = 1'b1;
        enqueue(0, it.slot);
        r.status = ST_ADMITTED;
        n_admitted++;
      end
      return r;
    end
    lv = 0;
    while (lv < LEVELS && ring_fill[lv] == 0) lv++;
    if (lv == LEVELS) begin
      // Idle tick: every field stays zero.
      r.status = ST_IDLE;
      n_idle++;
      return r;
    end
    who = ready_ring[lv][ring_head[lv]];
    ring_head[lv] = (ring_head[lv] + 1) % DEF_PROCESS_SLOTS;
    ring_fill[lv]--;
    owed = time_owed[who];
    // A zero slice runs nothing, yet the process still moves on.
    run  = ({8'd0, slice_now[lv]} < owed) ? {8'd0, slice_now[lv]} : owed;
    rest = owed - run;
    time_owed[who] = rest;
    r.slot_res = who;
    r.level    = lv[LVL_W-1:0];
    r.ran      = run[SLICE_W-1:0];
    r.left     = rest;
    if (rest == '0) begin
      slot_busy[who] = 1'b0;
      r.status = ST_TERMINATED;
      n_finished++;
    end else if (lv < int'(LVL_LOWEST)) begin
      enqueue(lv + 1, who);
      r.status = ST_DEMOTED;
      n_moved_down++;
    end else begin
      enqueue(lv, who);
      r.status = ST_REQUEUED;
      n_kept_low++;
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. Sampling at the rising edge reads the values from before
  // the edge, which is exactly when the handshake is judged.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sched_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing outstanding (status)", out_item.status, ST_IDLE);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          note_mismatch("status", out_item.status, want.status);
        if (out_item.slot_res !== want.slot_res)
          note_mismatch("slot_res", out_item.slot_res, want.slot_res);
        if (out_item.level !== want.level)
          note_mismatch("level", out_item.level, want.level);
        if (out_item.ran !== want.ran)
          note_mismatch("ran", out_item.ran, want.ran);
        if (out_item.left !== want.left)
          note_mismatch("left", out_item.left, want.left);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It stalls at random by recv_stall_pct, and when the stimulus asks
  // for it, holds off without a break so that the output register and the
  // execute stage fill and the input channel stalls.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. An item is offered after a random gap and held until the
  // block takes it; the expectation is queued at the edge of acceptance. The
  // valid is left high after acceptance, so a following item with no gap keeps
  // it high without it ever being lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic offer(sched_in_t it, bit typed, sched_out_t typed_want);
    sched_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = schedule_step(it);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  // Waits until every outstanding result has come back, then lets the block come
  // to rest. Anything still outstanding after the bound
  // is reported and dropped.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (pending_results.size() != 0) begin
      note_mismatch("result never delivered (status)", 'x, pending_results[0].status);
      void'(pending_results.pop_front());
    end
    repeat (4) @(posedge clk);
  endtask

  // One register write; the enable is lowered after the write edge and the port then
  // rests, so back-to-back writes never stack two assignments in a step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SLICE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx < LEVELS) slice_now[idx] = value;
    n_reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. A row is either a register write or a command; a command
  // row may carry the result typed in by hand, in which case that is what the
  // block must return (the mirror still runs to keep its state in step).
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [SLICE_W-1:0]   value;
    sched_in_t            item;
    bit                   typed;
    sched_out_t           want;
  } plan_row_t;

  function automatic plan_row_t item_row(logic cmd, int s, int b);
    plan_row_t row;
    row = '{default: '0};
    row.item.command = cmd;
    row.item.slot    = s[SLOT_W-1:0];
    row.item.burst   = b[TIME_W-1:0];
    return row;
  endfunction

  function automatic plan_row_t known_row(logic cmd, int s, int b, status_t st,
                                          int lv, int ran, int left);
    plan_row_t row;
    row = item_row(cmd, s, b);
    row.typed         = 1'b1;
    row.want.status   = st;
    row.want.slot_res = (st == ST_IDLE) ? '0 : s[SLOT_W-1:0];
    row.want.level    = lv[LVL_W-1:0];
    row.want.ran      = ran[SLICE_W-1:0];
    row.want.left     = left[TIME_W-1:0];
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int value);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.value  = value[SLICE_W-1:0];
    return row;
  endfunction

  function automatic sched_in_t random_command();
    sched_in_t it;
    int        pick;
    it.command = ($urandom_range(99) < 50) ? CMD_ADMIT : CMD_TICK;
    it.slot    = SLOT_W'($urandom_range(DEF_PROCESS_SLOTS - 1, 0));
    // Mostly short bursts so that processes come and go; some long ones, and
    // now and then a zero burst that must be turned away.
    pick = $urandom_range(99);
    if (pick < 3)       it.burst = '0;
    else if (pick < 70) it.burst = TIME_W'($urandom_range(40, 1));
    else if (pick < 92) it.burst = TIME_W'($urandom_range(1000, 1));
    else                it.burst = TIME_W'($urandom_range(65535, 1));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t  plan [$];
    sched_out_t no_want;
    int         ph;
    int         n;
    int         n_items;

    mismatches     = 0;
    n_admitted     = 0;
    n_turned_away  = 0;
    n_idle         = 0;
    n_finished     = 0;
    n_moved_down   = 0;
    n_kept_low     = 0;
    n_reg_writes   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked     = 0;
    n_items        = 0;
    no_want        = '0;

    // Mirror state after reset.
    for (int l = 0; l < LEVELS; l++) begin
      ring_head[l] = 0;
      ring_fill[l] = 0;
    end
    for (int s = 0; s < DEF_PROCESS_SLOTS; s++) begin
      time_owed[s] = '0;
      slot_busy[s] = 1'b0;
    end
    slice_now[0] = SLICE0_RST;
    slice_now[1] = SLICE1_RST;
    slice_now[2] = SLICE2_RST;

    // An idle tick straight after reset, the zero burst, the widest burst, a
    // slot that is already waiting, and a process walking down to level 2.
    plan.push_back(known_row(CMD_TICK, 0, 0, ST_IDLE, 0, 0, 0));
    plan.push_back(known_row(CMD_ADMIT, 0, 0, ST_REJECTED, 0, 0, 0));
    plan.push_back(known_row(CMD_ADMIT, 15, 65535, ST_ADMITTED, 0, 0, 65535));
    plan.push_back(known_row(CMD_ADMIT, 15, 5, ST_REJECTED, 0, 0, 5));
    plan.push_back(known_row(CMD_ADMIT, 0, 1, ST_ADMITTED, 0, 0, 1));
    plan.push_back(known_row(CMD_ADMIT, 5, 3, ST_ADMITTED, 0, 0, 3));
    repeat (6) plan.push_back(item_row(CMD_TICK, 0, 0));
    plan.push_back(known_row(CMD_ADMIT, 10, 16'hAAAA, ST_ADMITTED, 0, 0, 16'hAAAA));
    plan.push_back(known_row(CMD_ADMIT, 5, 16'h5555, ST_ADMITTED, 0, 0, 16'h5555));
    // Widest slices on the upper levels and a zero slice on the lowest one,
    // plus a write to the unused index, which must change nothing.
    plan.push_back(reg_row(REG_SLICE0, 255));
    plan.push_back(reg_row(REG_SLICE1, 255));
    plan.push_back(reg_row(REG_SLICE2, 0));
    plan.push_back(reg_row(REG_UNUSED, 255));
    repeat (6) plan.push_back(item_row(CMD_TICK, 0, 0));
    // Narrowest nonzero slice on level 0, a zero slice on level 1 and the widest on level 2.
    plan.push_back(reg_row(REG_SLICE0, 1));
    plan.push_back(reg_row(REG_SLICE1, 0));
    plan.push_back(reg_row(REG_SLICE2, 255));
    plan.push_back(known_row(CMD_ADMIT, 3, 2, ST_ADMITTED, 0, 0, 2));
    repeat (4) plan.push_back(item_row(CMD_TICK, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        offer(plan[i].item, plan[i].typed, plan[i].want);
        n_items++;
      end
    end

    // Random phases, each with its own slices and its own traffic pattern.
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_SLICE0, SLICE0_RST);
          write_reg(REG_SLICE1, SLICE1_RST);
          write_reg(REG_SLICE2, SLICE2_RST);
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          write_reg(REG_SLICE0, SLICE_W'(1));
          write_reg(REG_SLICE1, SLICE_W'(1));
          write_reg(REG_SLICE2, SLICE_W'(1));
          send_idle_pct = 85; recv_stall_pct = 0;
        end
        2: begin
          write_reg(REG_SLICE0, SLICE_W'(255));
          write_reg(REG_SLICE1, SLICE_W'(128));
          write_reg(REG_SLICE2, SLICE_W'(255));
          send_idle_pct = 0;  recv_stall_pct = 85;
        end
        3: begin
          write_reg(REG_SLICE0, SLICE_W'($urandom_range(20, 1)));
          write_reg(REG_SLICE1, SLICE_W'($urandom_range(20, 1)));
          write_reg(REG_SLICE2, SLICE_W'($urandom_range(20, 1)));
          send_idle_pct = 23; recv_stall_pct = 23;
        end
        4: begin
          // Pressure: the receiver goes quiet for a long stretch while the
          // sender keeps offering, so the block backs up onto its input.
          write_reg(REG_SLICE0, SLICE_W'($urandom_range(255, 1)));
          write_reg(REG_SLICE1, SLICE_W'($urandom_range(255, 1)));
          write_reg(REG_SLICE2, SLICE_W'($urandom_range(255, 1)));
          send_idle_pct = 0;  recv_stall_pct = 0;
          hold_asked++;
        end
        default: begin
          write_reg(REG_SLICE0, SLICE_W'($urandom_range(16, 1)));
          write_reg(REG_SLICE1, SLICE_W'($urandom_range(16, 1)));
          write_reg(REG_SLICE2, SLICE_W'($urandom_range(16, 1)));
          send_idle_pct = 50; recv_stall_pct = 50;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        offer(random_command(), 1'b0, no_want);
        n_items++;
      end
    end

    settle();
    repeat (10) @(posedge clk);

    $display("Covered %0d items over %0d register writes: %0d admitted, %0d turned away;",
             n_items, n_reg_writes, n_admitted, n_turned_away);
    $display("ticks: %0d idle, %0d finished, %0d moved down, %0d kept on the lowest level.",
             n_idle, n_finished, n_moved_down, n_kept_low);
    if (mismatches == 0) begin
      $display("PASS mlfq_scheduler_tick");
    end else begin
      $display("FAIL mlfq_scheduler_tick");
    end
    $finish;
  end

endmodule
